/* hw/rtl/lrb_pkg.sv */
package lrb_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned REASON_W = 8;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned DELAY_W = 24;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned ATTEMPT_W = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned MSEC_W = 10;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [MSEC_W-1:0] MS_PER_SECOND = 10'd1000;

  localparam logic [DELAY_W-1:0] BASE_DELAY_RESET = 24'd2000;
  localparam logic [DELAY_W-1:0] MAX_DELAY_RESET = 24'd30000;
  localparam logic [DELAY_W-1:0] CONNECT_TIMEOUT_RESET = 24'd10000;
  localparam logic [WINDOW_W-1:0] SPURIOUS_WINDOW_RESET = 16'd500;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_BEGIN      = 3'd1,
    ACT_ADDRESS    = 3'd2,
    ACT_LINK_LOST  = 3'd3,
    ACT_RECONNECT  = 3'd4,
    ACT_DISCONNECT = 3'd5
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_DELAY      = 2'd0,
    REG_MAX_DELAY       = 2'd1,
    REG_CONNECT_TIMEOUT = 2'd2,
    REG_SPURIOUS_WINDOW = 2'd3
  } cfg_reg_t;

endpackage

/* hw/rtl/lrb_in_if.sv */
interface lrb_in_if import lrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [REASON_W-1:0] reason;

  modport source (output valid, output action, output reason, input ready);
  modport sink (input valid, input action, input reason, output ready);
endinterface

/* hw/rtl/lrb_out_if.sv */
interface lrb_out_if import lrb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   link_state;
  logic                 start_attempt;
  logic                 drop_link;
  logic [ATTEMPT_W-1:0] retry_attempt;
  logic [COUNT_W-1:0]   retries_done;
  logic [REASON_W-1:0]  last_reason;
  logic [DELAY_W-1:0]   backoff_left_ms;
  logic [COUNT_W-1:0]   connected_seconds;

  modport source (output valid, output link_state, output start_attempt, output drop_link,
                  output retry_attempt, output retries_done, output last_reason,
                  output backoff_left_ms, output connected_seconds, input ready);
  modport sink (input valid, input link_state, input start_attempt, input drop_link,
                input retry_attempt, input retries_done, input last_reason,
                input backoff_left_ms, input connected_seconds, output ready);
endinterface

/* hw/rtl/link_reconnect_backoff_fsm_unit.sv */
// Link connection controller with exponential retry backoff. Each input transfer is either a
// one-millisecond tick or a link event, and produces exactly one result transfer that shows the
// link state after the event, the start and drop pulses, and the retry, reason, backoff and
// uptime counters. The update is combinational from the input handshake to the output
// register, so a transfer is taken every cycle unless the output stalls, and its result shows
// in the cycle after; the output register lets a new transfer in while the last is taken.
// The retry delay is the base delay shifted left by the failed attempt count and limited to the
// maximum delay. Configuration writes take effect on the next transfer and are meant for idle.
module link_reconnect_backoff_fsm_unit import lrb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lrb_in_if.sink                 in_ch,
  lrb_out_if.source              out_ch
);

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE         = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_CONNECTED    = 3'd2,
    ST_RECONNECTING = 3'd3,
    ST_DISCONNECTED = 3'd4
  } state_t;

  localparam logic [ATTEMPT_W-1:0] SHIFT_LIMIT = ATTEMPT_W'(DELAY_W);

  logic [DELAY_W-1:0]   base_delay;
  logic [DELAY_W-1:0]   max_delay;
  logic [DELAY_W-1:0]   connect_timeout;
  logic [WINDOW_W-1:0]  spurious_window;

  state_t               state, state_next;
  logic [DELAY_W-1:0]   elapsed, elapsed_next;
  logic [DELAY_W-1:0]   backoff, backoff_next;
  logic [ATTEMPT_W-1:0] fails, fails_next;
  logic [COUNT_W-1:0]   retries, retries_next;
  logic [REASON_W-1:0]  saved_reason, saved_reason_next;
  logic [MSEC_W-1:0]    msec, msec_next;
  logic [COUNT_W-1:0]   secs, secs_next;
  logic                 start_pulse, drop_pulse;

  logic                 accept;
  action_t              act;
  logic [DELAY_W-1:0]   elapsed_inc;
  logic [ATTEMPT_W-1:0] fails_inc;
  logic [MSEC_W-1:0]    msec_inc;
  logic [2*DELAY_W-1:0] shifted;
  logic [DELAY_W-1:0]   delay;

  assign in_ch.ready = !rst && (!out_ch.valid || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign act = action_t'(in_ch.action);

  assign elapsed_inc = (elapsed != '1) ? elapsed + 1'b1 : elapsed;
  assign fails_inc = (fails != '1) ? fails + 1'b1 : fails;
  assign msec_inc = msec + 1'b1;
  assign shifted = {{DELAY_W{1'b0}}, base_delay} << fails[$clog2(DELAY_W)-1:0];

  always_comb begin
    if (base_delay == '0) begin
      delay = '0;
    end else if (fails >= SHIFT_LIMIT) begin
      delay = max_delay;
    end else if (shifted > {{DELAY_W{1'b0}}, max_delay}) begin
      delay = max_delay;
    end else begin
      delay = shifted[DELAY_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    elapsed_next = elapsed;
    backoff_next = backoff;
    fails_next = fails;
    retries_next = retries;
    saved_reason_next = saved_reason;
    msec_next = msec;
    secs_next = secs;
    start_pulse = 1'b0;
    drop_pulse = 1'b0;
    unique case (act)
      ACT_TICK: begin
        elapsed_next = elapsed_inc;
        unique case (state)
          ST_CONNECTING: begin
            if (elapsed_inc >= connect_timeout) begin
              backoff_next = delay;
              fails_next = fails_inc;
              state_next = ST_RECONNECTING;
            end
          end
          ST_RECONNECTING: begin
            if (backoff <= DELAY_W'(1)) begin
              retries_next = retries + 1'b1;
              start_pulse = 1'b1;
              elapsed_next = '0;
              backoff_next = '0;
              state_next = ST_CONNECTING;
            end else begin
              backoff_next = backoff - 1'b1;
            end
          end
          ST_CONNECTED: begin
            if (msec_inc >= MS_PER_SECOND) begin
              msec_next = '0;
              secs_next = (secs != '1) ? secs + 1'b1 : secs;
            end else begin
              msec_next = msec_inc;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_BEGIN: begin
        start_pulse = 1'b1;
        elapsed_next = '0;
        backoff_next = '0;
        state_next = ST_CONNECTING;
      end
      ACT_ADDRESS: begin
        if (state == ST_CONNECTING) begin
          fails_next = '0;
          backoff_next = '0;
          msec_next = '0;
          secs_next = '0;
          state_next = ST_CONNECTED;
        end
      end
      ACT_LINK_LOST: begin
        saved_reason_next = in_ch.reason;
        if (elapsed >= {{(DELAY_W-WINDOW_W){1'b0}}, spurious_window}
            && (state == ST_CONNECTED || state == ST_CONNECTING)) begin
          backoff_next = delay;
          fails_next = fails_inc;
          state_next = ST_RECONNECTING;
        end
      end
      ACT_RECONNECT: begin
        fails_next = '0;
        start_pulse = 1'b1;
        elapsed_next = '0;
        backoff_next = '0;
        state_next = ST_CONNECTING;
      end
      ACT_DISCONNECT: begin
        drop_pulse = 1'b1;
        backoff_next = '0;
        state_next = ST_DISCONNECTED;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay <= BASE_DELAY_RESET;
      max_delay <= MAX_DELAY_RESET;
      connect_timeout <= CONNECT_TIMEOUT_RESET;
      spurious_window <= SPURIOUS_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_DELAY:      base_delay <= cfg_data;
        REG_MAX_DELAY:       max_delay <= cfg_data;
        REG_CONNECT_TIMEOUT: connect_timeout <= cfg_data;
        REG_SPURIOUS_WINDOW: spurious_window <= cfg_data[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      elapsed <= '0;
      backoff <= '0;
      fails <= '0;
      retries <= '0;
      saved_reason <= '0;
      msec <= '0;
      secs <= '0;
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      state <= state_next;
      elapsed <= elapsed_next;
      backoff <= backoff_next;
      fails <= fails_next;
      retries <= retries_next;
      saved_reason <= saved_reason_next;
      msec <= msec_next;
      secs <= secs_next;
      out_ch.valid <= 1'b1;
      out_ch.link_state <= state_next;
      out_ch.start_attempt <= start_pulse;
      out_ch.drop_link <= drop_pulse;
      out_ch.retry_attempt <= fails_next;
      out_ch.retries_done <= retries_next;
      out_ch.last_reason <= saved_reason_next;
      out_ch.backoff_left_ms <= backoff_next;
      out_ch.connected_seconds <= (state_next == ST_CONNECTED) ? secs_next : '0;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

endmodule
